FILE: hdl/rsx_pkg.sv
// ----------------------------------------------------------------------------
// rsx_pkg
// Shared types and constants for the ray and segment crossing block.
// ----------------------------------------------------------------------------
package rsx_pkg;

  localparam int CoordW     = 32;
  localparam int DiffW      = 33;
  localparam int ProdW      = 68;
  localparam int MagW       = 67;
  localparam int MulW       = 34;
  localparam int NumW       = 101;
  localparam int QuotW      = 41;
  localparam int TolW       = 8;
  localparam int QueueDepth = 4;

  localparam logic [TolW-1:0]  TolReset  = 8'd1;
  localparam logic [QuotW-1:0] QuotLimit = 41'h100_0000_0000;

  typedef enum logic [1:0] {
    CLS_MISS,
    CLS_BOTH,
    CLS_ONE,
    CLS_GEN
  } cls_t;

  typedef enum logic [1:0] {
    DST_X,
    DST_Y,
    DST_Z
  } dst_t;

  typedef struct packed {
    cls_t                      cls;
    logic signed [CoordW-1:0]  sx;
    logic signed [CoordW-1:0]  sz;
    logic signed [CoordW-1:0]  dx;
    logic signed [CoordW-1:0]  dz;
    logic signed [CoordW-1:0]  ax;
    logic signed [CoordW-1:0]  ay;
    logic signed [CoordW-1:0]  az;
    logic signed [CoordW-1:0]  bx;
    logic signed [CoordW-1:0]  by;
    logic signed [CoordW-1:0]  bz;
    logic signed [DiffW-1:0]   dbx;
    logic signed [DiffW-1:0]   dby;
    logic signed [DiffW-1:0]   dbz;
    logic signed [DiffW-1:0]   dsx;
    logic signed [DiffW-1:0]   dsz;
    logic signed [CoordW-1:0]  xr;
    logic signed [CoordW-1:0]  zr;
    logic                      lerp_en;
    dst_t                      lerp_dst;
    logic signed [CoordW-1:0]  lerp_base;
    logic signed [DiffW-1:0]   lerp_off;
    logic signed [DiffW-1:0]   lerp_num;
    logic signed [DiffW-1:0]   lerp_den;
  } job_t;

endpackage

FILE: hdl/rsx_front.sv
// ----------------------------------------------------------------------------
// rsx_front
// Classifies a request: tolerance tests, fixed coordinates and the case to run.
// ----------------------------------------------------------------------------
module rsx_front (
  input  logic [rsx_pkg::TolW-1:0]          tol,
  input  logic signed [rsx_pkg::CoordW-1:0] start_x,
  input  logic signed [rsx_pkg::CoordW-1:0] start_z,
  input  logic signed [rsx_pkg::CoordW-1:0] dir_x,
  input  logic signed [rsx_pkg::CoordW-1:0] dir_z,
  input  logic signed [rsx_pkg::CoordW-1:0] end_a_x,
  input  logic signed [rsx_pkg::CoordW-1:0] end_a_y,
  input  logic signed [rsx_pkg::CoordW-1:0] end_a_z,
  input  logic signed [rsx_pkg::CoordW-1:0] end_b_x,
  input  logic signed [rsx_pkg::CoordW-1:0] end_b_y,
  input  logic signed [rsx_pkg::CoordW-1:0] end_b_z,
  output rsx_pkg::job_t                     job
);

  function automatic logic near(input logic signed [32:0] v, input logic [7:0] t);
    logic signed [33:0] w;
    logic signed [33:0] tt;
    w    = 34'(v);
    tt   = $signed({26'b0, t});
    near = (w <= tt) && (-w <= tt);
  endfunction

  logic signed [32:0] dx33, dz33, dbx, dby, dbz, dsx, dsz;
  logic signed [31:0] xr, zr;
  logic               xs, zs, miss;

  always_comb begin
    dx33 = 33'(dir_x);
    dz33 = 33'(dir_z);
    dbx  = 33'(end_b_x) - 33'(end_a_x);
    dby  = 33'(end_b_y) - 33'(end_a_y);
    dbz  = 33'(end_b_z) - 33'(end_a_z);
    dsx  = 33'(start_x) - 33'(end_a_x);
    dsz  = 33'(start_z) - 33'(end_a_z);

    xs   = near(dx33, tol);
    zs   = near(dz33, tol);
    xr   = xs ? start_x : '0;
    zr   = zs ? start_z : '0;
    miss = 1'b0;

    if (near(dbx, tol)) begin
      if (xs) begin
        if (end_a_x != xr) miss = 1'b1;
      end else begin
        xs = 1'b1;
        xr = end_a_x;
      end
    end
    if (!miss && near(dbz, tol)) begin
      if (zs) begin
        if (end_a_z != zr) miss = 1'b1;
      end else begin
        zs = 1'b1;
        zr = end_a_z;
      end
    end

    job           = '0;
    job.sx        = start_x;
    job.sz        = start_z;
    job.dx        = dir_x;
    job.dz        = dir_z;
    job.ax        = end_a_x;
    job.ay        = end_a_y;
    job.az        = end_a_z;
    job.bx        = end_b_x;
    job.by        = end_b_y;
    job.bz        = end_b_z;
    job.dbx       = dbx;
    job.dby       = dby;
    job.dbz       = dbz;
    job.dsx       = dsx;
    job.dsz       = dsz;
    job.lerp_dst  = rsx_pkg::DST_X;

    if (miss) begin
      job.cls = rsx_pkg::CLS_MISS;
    end else if (xs && zs) begin
      job.cls = rsx_pkg::CLS_BOTH;
    end else if (xs) begin
      job.cls = rsx_pkg::CLS_ONE;
      if (dir_x != '0) begin
        job.lerp_en   = 1'b1;
        job.lerp_dst  = rsx_pkg::DST_Z;
        job.lerp_base = start_z;
        job.lerp_off  = 33'(xr) - 33'(start_x);
        job.lerp_num  = dz33;
        job.lerp_den  = dx33;
      end else if (dbx != '0) begin
        job.lerp_en   = 1'b1;
        job.lerp_dst  = rsx_pkg::DST_Z;
        job.lerp_base = end_a_z;
        job.lerp_off  = 33'(xr) - 33'(end_a_x);
        job.lerp_num  = dbz;
        job.lerp_den  = dbx;
      end else if (dir_z < 0) begin
        zr = (end_a_z < end_b_z) ? end_a_z : end_b_z;
      end else begin
        zr = (end_a_z > end_b_z) ? end_a_z : end_b_z;
      end
    end else if (zs) begin
      job.cls = rsx_pkg::CLS_ONE;
      if (dir_z != '0) begin
        job.lerp_en   = 1'b1;
        job.lerp_dst  = rsx_pkg::DST_X;
        job.lerp_base = start_x;
        job.lerp_off  = 33'(zr) - 33'(start_z);
        job.lerp_num  = dx33;
        job.lerp_den  = dz33;
      end else if (dbz != '0) begin
        job.lerp_en   = 1'b1;
        job.lerp_dst  = rsx_pkg::DST_X;
        job.lerp_base = end_a_x;
        job.lerp_off  = 33'(zr) - 33'(end_a_z);
        job.lerp_num  = dbx;
        job.lerp_den  = dbz;
      end else if (dir_x < 0) begin
        xr = (end_a_x < end_b_x) ? end_a_x : end_b_x;
      end else begin
        xr = (end_a_x > end_b_x) ? end_a_x : end_b_x;
      end
    end else begin
      job.cls = rsx_pkg::CLS_GEN;
    end

    job.xr = xr;
    job.zr = zr;
  end

endmodule

FILE: hdl/rsx_queue.sv
// ----------------------------------------------------------------------------
// rsx_queue
// Short first-in first-out buffer of classified requests.
// ----------------------------------------------------------------------------
module rsx_queue #(
  parameter int DEPTH = rsx_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rsx_pkg::job_t wdata,
  input  logic          pop,
  output rsx_pkg::job_t rdata,
  output logic          valid,
  output logic          full
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  rsx_pkg::job_t   mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign rdata = mem[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == CntW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: hdl/rsx_div.sv
// ----------------------------------------------------------------------------
// rsx_div
// Restoring divider, one quotient bit per cycle, quotient clamped to 2^40.
// ----------------------------------------------------------------------------
module rsx_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [rsx_pkg::NumW-1:0]    num,
  input  logic [rsx_pkg::MagW-1:0]    den,
  output logic                        done,
  output logic [rsx_pkg::QuotW-1:0]   quot
);

  localparam int CntW = $clog2(rsx_pkg::NumW + 1);

  logic [rsx_pkg::NumW-1:0]  nsh;
  logic [rsx_pkg::MagW-1:0]  rem;
  logic [rsx_pkg::MagW:0]    rem_sh, rem_nx;
  logic [rsx_pkg::QuotW:0]   q;
  logic                      over, run, ge;
  logic [CntW-1:0]           cnt;

  always_comb begin
    rem_sh = {rem, nsh[rsx_pkg::NumW-1]};
    ge     = (rem_sh >= {1'b0, den});
    rem_nx = ge ? rem_sh - {1'b0, den} : rem_sh;
    done   = run && (cnt == '0);
    quot   = (over || (q > {1'b0, rsx_pkg::QuotLimit})) ? rsx_pkg::QuotLimit
                                                        : q[rsx_pkg::QuotW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (go) begin
      run <= 1'b1;
    end else if (done) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      nsh  <= num;
      rem  <= '0;
      q    <= '0;
      over <= 1'b0;
      cnt  <= CntW'(rsx_pkg::NumW);
    end else if (run && (cnt != '0)) begin
      nsh  <= nsh << 1;
      rem  <= rem_nx[rsx_pkg::MagW-1:0];
      over <= over | (q >= {1'b0, rsx_pkg::QuotLimit});
      q    <= {q[rsx_pkg::QuotW-1:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

FILE: hdl/rsx_back.sv
// ----------------------------------------------------------------------------
// rsx_back
// Carries out one classified request: products, ratio divisions, range and
// direction checks, height interpolation and the result strobe.
// ----------------------------------------------------------------------------
module rsx_back (
  input  logic                              clk,
  input  logic                              rst,
  input  rsx_pkg::job_t                     head,
  input  logic                              head_valid,
  output logic                              pop,
  output logic                              done,
  output logic                              hit,
  output logic signed [rsx_pkg::CoordW-1:0] cross_x,
  output logic signed [rsx_pkg::CoordW-1:0] cross_y,
  output logic signed [rsx_pkg::CoordW-1:0] cross_z
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_PROD  = 9'b000000100,
    S_COMB  = 9'b000001000,
    S_DMLO  = 9'b000010000,
    S_DMHI  = 9'b000100000,
    S_DNUM  = 9'b001000000,
    S_DWAIT = 9'b010000000,
    S_CHK   = 9'b100000000
  } state_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [66:0] mag68(input logic signed [67:0] v);
    logic signed [67:0] n;
    n     = -v;
    mag68 = v[67] ? n[66:0] : v[66:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -43'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  state_t              state, state_next;
  rsx_pkg::job_t       jb;
  logic [2:0]          pc, nprod;
  logic [1:0]          pidx;
  logic signed [67:0]  p [4];
  logic [67:0]         mp, lo_keep;
  logic                msign;
  logic [66:0]         dv_a, dv_d, ld_a, ld_d;
  logic [33:0]         dv_b, ld_b, ma, mb;
  logic                dv_neg, ld_neg, ld, gnum_neg, gden_neg;
  logic signed [31:0]  dv_base, ld_base;
  rsx_pkg::dst_t       dv_dst, ld_dst;
  logic signed [31:0]  xr, zr;

  logic signed [31:0]  sx, sz, dx, dz, ax, ay, az, bx, by, bz;
  logic signed [32:0]  dbx, dby, dbz, dsx, dsz, dx33, dz33;
  logic signed [32:0]  l_off, l_num, l_den, y_off, y_den, op_a, op_b;
  logic signed [67:0]  den_w, num_w;
  logic signed [42:0]  qs, bs;
  logic signed [31:0]  res, e_y, ymax;
  logic                emit, e_hit, fail, div_done;
  logic [40:0]         div_q;
  logic [100:0]        div_num;

  assign sx    = jb.sx;
  assign sz    = jb.sz;
  assign dx    = jb.dx;
  assign dz    = jb.dz;
  assign ax    = jb.ax;
  assign ay    = jb.ay;
  assign az    = jb.az;
  assign bx    = jb.bx;
  assign by    = jb.by;
  assign bz    = jb.bz;
  assign dbx   = jb.dbx;
  assign dby   = jb.dby;
  assign dbz   = jb.dbz;
  assign dsx   = jb.dsx;
  assign dsz   = jb.dsz;
  assign l_off = jb.lerp_off;
  assign l_num = jb.lerp_num;
  assign l_den = jb.lerp_den;
  assign dx33  = 33'(dx);
  assign dz33  = 33'(dz);

  assign pop     = (state == S_IDLE) && head_valid;
  assign nprod   = (jb.cls == rsx_pkg::CLS_BOTH) ? 3'd2 : 3'd4;
  assign pidx    = 2'(pc - 3'd1);
  assign div_num = 101'(lo_keep) + (101'(mp) << 34);

  rsx_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (state == S_DNUM),
    .num  (div_num),
    .den  (dv_d),
    .done (div_done),
    .quot (div_q)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (jb.cls == rsx_pkg::CLS_BOTH) begin
      case (pc)
        3'd0: begin op_a = dsx; op_b = dbz; end
        3'd1: begin op_a = dbx; op_b = dsz; end
        default: ;
      endcase
    end else begin
      case (pc)
        3'd0: begin op_a = dbx; op_b = dz33; end
        3'd1: begin op_a = dbz; op_b = dx33; end
        3'd2: begin op_a = dsx; op_b = dz33; end
        3'd3: begin op_a = dsz; op_b = dx33; end
        default: ;
      endcase
    end
  end

  always_comb begin
    den_w = p[0] - p[1];
    num_w = p[2] - p[3];
    qs    = dv_neg ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
    bs    = 43'(dv_base);
    res   = sat32(bs + qs);
    fail  = (xr < ((ax < bx) ? ax : bx)) || (xr > ((ax > bx) ? ax : bx)) ||
            (zr < ((az < bz) ? az : bz)) || (zr > ((az > bz) ? az : bz)) ||
            ((xr > sx) && (dx < 0)) || ((xr < sx) && (dx > 0)) ||
            ((zr > sz) && (dz < 0)) || ((zr < sz) && (dz > 0));
    ymax  = (ay > by) ? ay : by;
    y_off = (dbx == '0) ? 33'(zr) - 33'(az) : 33'(xr) - 33'(ax);
    y_den = (dbx == '0) ? dbz : dbx;
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    e_hit      = 1'b0;
    e_y        = '0;
    ld         = 1'b0;
    ld_a       = dv_a;
    ld_b       = dv_b;
    ld_d       = dv_d;
    ld_neg     = dv_neg;
    ld_base    = dv_base;
    ld_dst     = dv_dst;
    ma         = '0;
    mb         = '0;
    unique case (state)
      S_IDLE: begin
        if (head_valid) state_next = S_START;
      end
      S_START: begin
        case (jb.cls)
          rsx_pkg::CLS_MISS: begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
          rsx_pkg::CLS_ONE: begin
            if (jb.lerp_en) begin
              ld         = 1'b1;
              ld_a       = 67'(mag33(l_off));
              ld_b       = 34'(mag33(l_num));
              ld_d       = 67'(mag33(l_den));
              ld_neg     = l_off[32] ^ l_num[32] ^ l_den[32];
              ld_base    = jb.lerp_base;
              ld_dst     = jb.lerp_dst;
              state_next = S_DMLO;
            end else begin
              state_next = S_CHK;
            end
          end
          default: state_next = S_PROD;
        endcase
      end
      S_PROD: begin
        ma = 34'(mag33(op_a));
        mb = 34'(mag33(op_b));
        if (pc == nprod) state_next = S_COMB;
      end
      S_COMB: begin
        if (jb.cls == rsx_pkg::CLS_BOTH) begin
          if (p[0] == p[1]) begin
            state_next = S_CHK;
          end else begin
            emit       = 1'b1;
            state_next = S_IDLE;
          end
        end else if (den_w == '0) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          ld         = 1'b1;
          ld_a       = mag68(num_w);
          ld_b       = 34'(mag33(dbx));
          ld_d       = mag68(den_w);
          ld_neg     = num_w[67] ^ dbx[32] ^ den_w[67];
          ld_base    = ax;
          ld_dst     = rsx_pkg::DST_X;
          state_next = S_DMLO;
        end
      end
      S_DMLO: begin
        ma         = dv_a[33:0];
        mb         = dv_b;
        state_next = S_DMHI;
      end
      S_DMHI: begin
        ma         = {1'b0, dv_a[66:34]};
        mb         = dv_b;
        state_next = S_DNUM;
      end
      S_DNUM: begin
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          unique case (dv_dst)
            rsx_pkg::DST_X: begin
              if (jb.cls == rsx_pkg::CLS_GEN) begin
                ld         = 1'b1;
                ld_b       = 34'(mag33(dbz));
                ld_neg     = gnum_neg ^ dbz[32] ^ gden_neg;
                ld_base    = az;
                ld_dst     = rsx_pkg::DST_Z;
                state_next = S_DMLO;
              end else begin
                state_next = S_CHK;
              end
            end
            rsx_pkg::DST_Z: state_next = S_CHK;
            rsx_pkg::DST_Y: begin
              emit       = 1'b1;
              e_hit      = 1'b1;
              e_y        = res;
              state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CHK: begin
        if (fail) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else if ((dbx == '0) && (dbz == '0)) begin
          emit       = 1'b1;
          e_hit      = 1'b1;
          e_y        = ymax;
          state_next = S_IDLE;
        end else begin
          ld         = 1'b1;
          ld_a       = 67'(mag33(y_off));
          ld_b       = 34'(mag33(dby));
          ld_d       = 67'(mag33(y_den));
          ld_neg     = y_off[32] ^ dby[32] ^ y_den[32];
          ld_base    = ay;
          ld_dst     = rsx_pkg::DST_Y;
          state_next = S_DMLO;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    mp <= {34'b0, ma} * {34'b0, mb};
    if (pop) begin
      jb <= head;
      xr <= head.xr;
      zr <= head.zr;
      pc <= '0;
    end
    if (state == S_PROD) begin
      pc    <= pc + 1'b1;
      msign <= op_a[32] ^ op_b[32];
      if (pc != '0) begin
        p[pidx] <= msign ? -$signed(mp) : $signed(mp);
      end
    end
    if (state == S_COMB) begin
      gnum_neg <= num_w[67];
      gden_neg <= den_w[67];
    end
    if (state == S_DMHI) begin
      lo_keep <= mp;
    end
    if (ld) begin
      dv_a    <= ld_a;
      dv_b    <= ld_b;
      dv_d    <= ld_d;
      dv_neg  <= ld_neg;
      dv_base <= ld_base;
      dv_dst  <= ld_dst;
    end
    if ((state == S_DWAIT) && div_done) begin
      case (dv_dst)
        rsx_pkg::DST_X: xr <= res;
        rsx_pkg::DST_Z: zr <= res;
        default: ;
      endcase
    end
    if (emit) begin
      hit     <= e_hit;
      cross_x <= e_hit ? xr : '0;
      cross_y <= e_hit ? e_y : '0;
      cross_z <= e_hit ? zr : '0;
    end
  end

endmodule

FILE: hdl/ray_segment_cross_xz.sv
// ----------------------------------------------------------------------------
// ray_segment_cross_xz
// Crossing of a ray with the XZ projection of a 3D segment, Q16.16.
//
//   channel   direction  handshake              payload
//   request   in         start, busy            start_x .. end_b_z
//   result    out        done (one cycle)       hit, cross_x, cross_y, cross_z
//   config    in         cfg_valid, cfg_ready   cfg_data (equal tolerance)
//
// A request is classified on the cycle it is taken and waits in a four-entry
// queue; busy is high only while that queue is full.
// An early miss needs no divide; each divide goes through the shared
// one-bit-per-cycle divider, so the divider sets the sustained rate, and a new
// request leaves the queue only once the last result is emitted.
// Reset is synchronous and returns the tolerance to 1 and empties the queue.
// The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module ray_segment_cross_xz #(
  parameter int QUEUE_DEPTH = rsx_pkg::QueueDepth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rsx_pkg::CoordW-1:0] start_x,
  input  logic signed [rsx_pkg::CoordW-1:0] start_z,
  input  logic signed [rsx_pkg::CoordW-1:0] dir_x,
  input  logic signed [rsx_pkg::CoordW-1:0] dir_z,
  input  logic signed [rsx_pkg::CoordW-1:0] end_a_x,
  input  logic signed [rsx_pkg::CoordW-1:0] end_a_y,
  input  logic signed [rsx_pkg::CoordW-1:0] end_a_z,
  input  logic signed [rsx_pkg::CoordW-1:0] end_b_x,
  input  logic signed [rsx_pkg::CoordW-1:0] end_b_y,
  input  logic signed [rsx_pkg::CoordW-1:0] end_b_z,
  output logic                              done,
  output logic                              hit,
  output logic signed [rsx_pkg::CoordW-1:0] cross_x,
  output logic signed [rsx_pkg::CoordW-1:0] cross_y,
  output logic signed [rsx_pkg::CoordW-1:0] cross_z,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsx_pkg::TolW-1:0]          cfg_data
);

  logic [rsx_pkg::TolW-1:0] eq_tol;
  rsx_pkg::job_t            fjob, qjob;
  logic                     q_valid, q_full, q_pop;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      eq_tol <= rsx_pkg::TolReset;
    end else if (cfg_valid && cfg_ready) begin
      eq_tol <= cfg_data;
    end
  end

  rsx_front u_front (
    .tol     (eq_tol),
    .start_x (start_x),
    .start_z (start_z),
    .dir_x   (dir_x),
    .dir_z   (dir_z),
    .end_a_x (end_a_x),
    .end_a_y (end_a_y),
    .end_a_z (end_a_z),
    .end_b_x (end_b_x),
    .end_b_y (end_b_y),
    .end_b_z (end_b_z),
    .job     (fjob)
  );

  rsx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (start && !busy),
    .wdata (fjob),
    .pop   (q_pop),
    .rdata (qjob),
    .valid (q_valid),
    .full  (q_full)
  );

  rsx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (qjob),
    .head_valid (q_valid),
    .pop        (q_pop),
    .done       (done),
    .hit        (hit),
    .cross_x    (cross_x),
    .cross_y    (cross_y),
    .cross_z    (cross_z)
  );

endmodule

FILE: hdl/rsx_checker.sv
// ----------------------------------------------------------------------------
// rsx_checker
// Port-level checks on reset and the result strobe of the crossing block.
// ----------------------------------------------------------------------------
module rsx_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              busy,
  input logic                              done,
  input logic                              hit,
  input logic signed [rsx_pkg::CoordW-1:0] cross_x,
  input logic signed [rsx_pkg::CoordW-1:0] cross_y,
  input logic signed [rsx_pkg::CoordW-1:0] cross_z
);

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> ((cross_x == '0) && (cross_y == '0) && (cross_z == '0)))
    else $error("miss result carries a nonzero point");

  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results on consecutive cycles");

  a_rst_done: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  a_rst_busy: assert property (@(posedge clk)
    $past(rst) |-> !busy)
    else $error("busy right after reset");

endmodule

bind ray_segment_cross_xz rsx_checker u_rsx_checker (
  .clk     (clk),
  .rst     (rst),
  .busy    (busy),
  .done    (done),
  .hit     (hit),
  .cross_x (cross_x),
  .cross_y (cross_y),
  .cross_z (cross_z)
);
